// ----- rtl/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, constants and helpers for the sparse COO mat-vec core.
// ----------------------------------------------------------------------------
package scm_pkg;

	localparam int VECTOR_DEPTH = 1024;
	localparam int ADDR_W = $clog2(VECTOR_DEPTH);
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		OP_WR_VEC = 2'd0,
		OP_WR_RES = 2'd1,
		OP_TRIPLE = 2'd2,
		OP_RD_RES = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [IDX_W-1:0]        result_index;
	} rsp_t;

	typedef struct packed {
		op_t                     op;
		logic                    row_ok;
		logic                    col_ok;
		addr_t                   row_addr;
		addr_t                   col_addr;
		logic [IDX_W-1:0]        row_index;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	function automatic logic idx_ok(logic [IDX_W-1:0] idx);
		return 32'(idx) < VECTOR_DEPTH;
	endfunction

	function automatic addr_t to_addr(logic [IDX_W-1:0] idx);
		logic [IDX_W+ADDR_W-1:0] ext;
		ext = (IDX_W + ADDR_W)'(idx);
		return ext[ADDR_W-1:0];
	endfunction

endpackage

// ----- rtl/scm_ram.sv -----
// ----------------------------------------------------------------------------
// scm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/scm_front.sv -----
// ----------------------------------------------------------------------------
// scm_front
// Accepts requests, decodes operation and index ranges, queues them (2 deep).
// ----------------------------------------------------------------------------
module scm_front import scm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic head_valid,
	output cmd_t head,
	input  logic pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cmd;

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_comb begin
		cmd.op = op_t'(request.operation);
		cmd.row_ok = idx_ok(request.row_index);
		cmd.col_ok = idx_ok(request.col_index);
		cmd.row_addr = to_addr(request.row_index);
		cmd.col_addr = to_addr(request.col_index);
		cmd.row_index = request.row_index;
		cmd.value = request.value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/scm_back.sv -----
// ----------------------------------------------------------------------------
// scm_back
// Executes queued commands against the vector and result memories.
// ----------------------------------------------------------------------------
module scm_back import scm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic subtract_mode,
	input  logic head_valid,
	input  cmd_t head,
	output logic pop,
	output logic result_strobe,
	output rsp_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_ACC
	} state_t;

	state_t                    state_q;
	cmd_t                      cmd_q;
	logic signed [2*VAL_W-1:0] prod_q;
	logic signed [VAL_W-1:0]   base_q;

	logic                    vec_we;
	logic                    res_we;
	logic                    vec_re;
	logic                    res_re;
	logic [VAL_W-1:0]        vec_rdata;
	logic [VAL_W-1:0]        res_rdata;
	logic [VAL_W-1:0]        res_wdata;
	addr_t                   res_waddr;
	logic signed [47:0]      term;
	logic signed [48:0]      acc;
	logic signed [VAL_W-1:0] acc_sat;

	assign pop = head_valid && (state_q == ST_IDLE);

	assign term = prod_q[2*VAL_W-1:16];

	always_comb begin
		if (subtract_mode) begin
			acc = 49'(base_q) - 49'(term);
		end else begin
			acc = 49'(base_q) + 49'(term);
		end
		if (acc[48:31] == {18{acc[48]}}) begin
			acc_sat = acc[31:0];
		end else if (acc[48]) begin
			acc_sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	always_comb begin
		vec_we = pop && (head.op == OP_WR_VEC) && head.col_ok;
		vec_re = pop && (head.op == OP_TRIPLE);
		res_re = pop && ((head.op == OP_TRIPLE) || (head.op == OP_RD_RES));
		if (state_q == ST_ACC) begin
			res_we = 1'b1;
			res_waddr = cmd_q.row_addr;
			res_wdata = acc_sat;
		end else begin
			res_we = pop && (head.op == OP_WR_RES) && head.row_ok;
			res_waddr = head.row_addr;
			res_wdata = head.value;
		end
	end

	scm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(VECTOR_DEPTH)
	) u_vec_ram (
		.clk  (clk),
		.we   (vec_we),
		.waddr(head.col_addr),
		.wdata(head.value),
		.re   (vec_re),
		.raddr(head.col_addr),
		.rdata(vec_rdata)
	);

	scm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(VECTOR_DEPTH)
	) u_res_ram (
		.clk  (clk),
		.we   (res_we),
		.waddr(res_waddr),
		.wdata(res_wdata),
		.re   (res_re),
		.raddr(head.row_addr),
		.rdata(res_rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == ST_MUL) begin
			prod_q <= cmd_q.value * $signed(vec_rdata);
			base_q <= $signed(res_rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_strobe <= 1'b0;
			result <= '0;
		end else begin
			result_strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.op == OP_RD_RES) begin
							state_q <= ST_READ;
						end else if (head.op == OP_TRIPLE && head.row_ok && head.col_ok) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_READ: begin
					result_strobe <= 1'b1;
					result.result_index <= cmd_q.row_index;
					result.result_value <= cmd_q.row_ok ? $signed(res_rdata) : '0;
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/sparse_coo_matvec_accumulate_core.sv -----
// ----------------------------------------------------------------------------
// sparse_coo_matvec_accumulate_core
// Sparse COO matrix-vector multiply-accumulate over vector and result memories.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge with start high and busy low. It
//   carries an operation, row and column indexes and a Q16.16 value:
//   write a vector entry, preset a result entry, apply a triple
//   (result[row] +/- value * vector[col], saturated), or read a result.
//   Requests wait in a two-entry queue; busy is high while it is full.
//   The executor takes one request at a time from the queue head:
//   writes complete when taken; a result read goes through ST_READ, a
//   triple through ST_MUL and ST_ACC (memory read, 32x32 multiply,
//   accumulate and write back). A read result appears on result for
//   exactly one cycle with result_strobe high; it passes through
//   the queue entry, the RAM read in ST_READ and the output register.
//   The receiver always takes it and cannot stall.
//   subtract_mode is written via subtract_mode_we/subtract_mode_wdata, by the
//   user only while the core is idle (not enforced). Reset empties the queue
//   and clears subtract_mode; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module sparse_coo_matvec_accumulate_core import scm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	input  logic subtract_mode_we,
	input  logic subtract_mode_wdata,
	output logic result_strobe,
	output rsp_t result
);

	logic subtract_mode_q;
	logic head_valid;
	cmd_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subtract_mode_q <= 1'b0;
		end else if (subtract_mode_we) begin
			subtract_mode_q <= subtract_mode_wdata;
		end
	end

	scm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	scm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.subtract_mode(subtract_mode_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_strobe(result_strobe),
		.result       (result)
	);

endmodule
